/* hw/rtl/plse_pkg.sv */
package plse_pkg;

    localparam int FUNC_W      = 3;
    localparam int POS_IN_W    = 6;
    localparam int DATA_OUT_W  = 32;
    localparam int COUNT_OUT_W = 7;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 3'd0,
        FUNC_REMOVE = 3'd1,
        FUNC_READ   = 3'd2,
        FUNC_SEARCH = 3'd3,
        FUNC_PUSH   = 3'd4,
        FUNC_POP    = 3'd5,
        FUNC_TOP    = 3'd6
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TREE,
        ST_RESP
    } state_t;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic rem;
        logic srch;
    } cell_ctrl_t;

endpackage

/* hw/rtl/plse_cell.sv */
module plse_cell #(
    parameter int INDEX      = 0,
    parameter int DATA_WIDTH = 32,
    parameter int PW         = 7,
    parameter int CW         = 7
) (
    input  logic                  aclk,
    input  plse_pkg::cell_ctrl_t  ctrl,
    input  logic [PW-1:0]         tgt_pos,
    input  logic [CW-1:0]         count,
    input  logic [DATA_WIDTH-1:0] key,
    input  logic [DATA_WIDTH-1:0] from_lo,
    input  logic [DATA_WIDTH-1:0] from_hi,
    output logic [DATA_WIDTH-1:0] entry,
    output logic                  hit
);

    localparam logic [PW-1:0] MY_POS = PW'(INDEX);
    localparam logic [CW-1:0] MY_CNT = CW'(INDEX);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins) begin
            if (MY_POS > tgt_pos) begin
                entry_next = from_lo;
            end else if (MY_POS == tgt_pos) begin
                entry_next = key;
            end
        end else if (ctrl.rem && (MY_POS >= tgt_pos)) begin
            entry_next = from_hi;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    // search: live entry equal to key; otherwise: this cell is the target position
    assign hit   = ctrl.srch ? ((entry_reg == key) && (MY_CNT < count)) : (MY_POS == tgt_pos);

endmodule

/* hw/rtl/plse_tree.sv */
module plse_tree #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  load,
    input  logic [CAPACITY-1:0]   leaf_hit,
    input  logic [DATA_WIDTH-1:0] leaf_data [CAPACITY],
    output logic                  root_hit,
    output logic [$clog2(CAPACITY)-1:0] root_idx,
    output logic [DATA_WIDTH-1:0] root_data
);

    localparam int IW     = $clog2(CAPACITY);
    localparam int LEAVES = 1 << IW;

    // heap layout: node k has children 2k and 2k+1, leaves at LEAVES..2*LEAVES-1
    logic                  hit_reg  [1:2*LEAVES-1];
    logic [IW-1:0]         idx_reg  [1:2*LEAVES-1];
    logic [DATA_WIDTH-1:0] data_reg [1:2*LEAVES-1];

    for (genvar gl = 0; gl < LEAVES; gl++) begin : g_leaf
        if (gl < CAPACITY) begin : g_used
            always_ff @(posedge aclk) begin
                if (load) begin
                    hit_reg[LEAVES+gl]  <= leaf_hit[gl];
                    idx_reg[LEAVES+gl]  <= IW'(gl);
                    data_reg[LEAVES+gl] <= leaf_data[gl];
                end
            end
        end else begin : g_pad
            always_ff @(posedge aclk) begin
                if (load) begin
                    hit_reg[LEAVES+gl]  <= 1'b0;
                    idx_reg[LEAVES+gl]  <= IW'(gl);
                    data_reg[LEAVES+gl] <= '0;
                end
            end
        end
    end

    // leftmost hit wins, one level per cycle
    for (genvar gk = 1; gk < LEAVES; gk++) begin : g_node
        always_ff @(posedge aclk) begin
            if (hit_reg[2*gk]) begin
                hit_reg[gk]  <= 1'b1;
                idx_reg[gk]  <= idx_reg[2*gk];
                data_reg[gk] <= data_reg[2*gk];
            end else begin
                hit_reg[gk]  <= hit_reg[2*gk+1];
                idx_reg[gk]  <= idx_reg[2*gk+1];
                data_reg[gk] <= data_reg[2*gk+1];
            end
        end
    end

    assign root_hit  = hit_reg[1];
    assign root_idx  = idx_reg[1];
    assign root_data = data_reg[1];

endmodule

/* hw/rtl/positional_list_stack_engine.sv */
// m_valid rises once an accepted item has passed execute, the registered find-first tree over
// the cells (one tree level per cycle) and the response state. A new item is taken only after
// the previous one leaves the response state, which holds while an unread result is pending.
// s_ready is high in idle even while a finished result waits in the output register.
// Reset (aresetn low, synchronous): list empty, no result pending; entries are not cleared.
module positional_list_stack_engine #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [plse_pkg::FUNC_W-1:0]       s_func,
    input  logic [plse_pkg::POS_IN_W-1:0]     s_position,
    input  logic [plse_pkg::DATA_OUT_W-1:0]   s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_status,
    output logic [plse_pkg::DATA_OUT_W-1:0]   m_data,
    output logic [plse_pkg::COUNT_OUT_W-1:0]  m_found_index,
    output logic                              m_found,
    output logic [plse_pkg::COUNT_OUT_W-1:0]  m_count
);

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int PW  = (CW > plse_pkg::POS_IN_W) ? CW : plse_pkg::POS_IN_W;
    localparam int IW  = $clog2(CAPACITY);
    localparam int LCW = $clog2(IW + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    plse_pkg::state_t                 state_reg, state_next;
    plse_pkg::func_t                  func_reg, func_next;
    logic [plse_pkg::POS_IN_W-1:0]    pos_reg, pos_next;
    logic [DATA_WIDTH-1:0]            value_reg, value_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic                             reject_reg, reject_next;
    logic [LCW-1:0]                   lvl_reg, lvl_next;

    logic                             m_valid_reg, m_valid_next;
    logic                             m_status_reg, m_status_next;
    logic [plse_pkg::DATA_OUT_W-1:0]  m_data_reg, m_data_next;
    logic [plse_pkg::COUNT_OUT_W-1:0] m_found_index_reg, m_found_index_next;
    logic                             m_found_reg, m_found_next;
    logic [plse_pkg::COUNT_OUT_W-1:0] m_count_reg, m_count_next;

    logic                  reject_c;
    logic                  ins_c;
    logic                  rem_c;
    logic                  wants_data;
    logic [PW-1:0]         pos_ext;
    logic [PW-1:0]         cnt_ext;
    logic [PW-1:0]         tgt_pos;
    plse_pkg::cell_ctrl_t  ctrl;

    logic [DATA_WIDTH-1:0] entry_w [CAPACITY];
    logic [CAPACITY-1:0]   hit_w;
    logic                  root_hit;
    logic [IW-1:0]         root_idx;
    logic [DATA_WIDTH-1:0] root_data;

    assign pos_ext = PW'(pos_reg);
    assign cnt_ext = PW'(count_reg);

    // decode of the held operation against the current fill count
    always_comb begin
        reject_c   = 1'b1;
        ins_c      = 1'b0;
        rem_c      = 1'b0;
        wants_data = 1'b0;
        tgt_pos    = pos_ext;
        unique case (func_reg)
            plse_pkg::FUNC_INSERT: begin
                reject_c = (count_reg >= CAP_C) || (pos_ext > cnt_ext);
                ins_c    = 1'b1;
            end
            plse_pkg::FUNC_PUSH: begin
                reject_c = (count_reg >= CAP_C);
                ins_c    = 1'b1;
                tgt_pos  = cnt_ext;
            end
            plse_pkg::FUNC_REMOVE: begin
                reject_c = (pos_ext >= cnt_ext);
                rem_c    = 1'b1;
            end
            plse_pkg::FUNC_READ: begin
                reject_c   = (pos_ext >= cnt_ext);
                wants_data = 1'b1;
            end
            plse_pkg::FUNC_SEARCH: begin
                reject_c = 1'b0;
            end
            plse_pkg::FUNC_POP, plse_pkg::FUNC_TOP: begin
                reject_c   = (count_reg == '0);
                wants_data = 1'b1;
                tgt_pos    = cnt_ext - PW'(1);
            end
            default: begin
                reject_c = 1'b1;
            end
        endcase
    end

    assign ctrl.ins  = (state_reg == plse_pkg::ST_EXEC) && ins_c && !reject_c;
    assign ctrl.rem  = (state_reg == plse_pkg::ST_EXEC) && rem_c && !reject_c;
    assign ctrl.srch = (func_reg == plse_pkg::FUNC_SEARCH);

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic [DATA_WIDTH-1:0] lo_w;
        logic [DATA_WIDTH-1:0] hi_w;
        if (gi == 0) begin : g_first
            assign lo_w = value_reg;
        end else begin : g_lo
            assign lo_w = entry_w[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_last
            assign hi_w = entry_w[gi];
        end else begin : g_hi
            assign hi_w = entry_w[gi+1];
        end
        plse_cell #(
            .INDEX      (gi),
            .DATA_WIDTH (DATA_WIDTH),
            .PW         (PW),
            .CW         (CW)
        ) u_cell (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .tgt_pos (tgt_pos),
            .count   (count_reg),
            .key     (value_reg),
            .from_lo (lo_w),
            .from_hi (hi_w),
            .entry   (entry_w[gi]),
            .hit     (hit_w[gi])
        );
    end

    plse_tree #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_tree (
        .aclk      (aclk),
        .load      (state_reg == plse_pkg::ST_EXEC),
        .leaf_hit  (hit_w),
        .leaf_data (entry_w),
        .root_hit  (root_hit),
        .root_idx  (root_idx),
        .root_data (root_data)
    );

    assign s_ready = (state_reg == plse_pkg::ST_IDLE);

    always_comb begin
        state_next         = state_reg;
        func_next          = func_reg;
        pos_next           = pos_reg;
        value_next         = value_reg;
        count_next         = count_reg;
        reject_next        = reject_reg;
        lvl_next           = lvl_reg;
        m_valid_next       = m_valid_reg;
        m_status_next      = m_status_reg;
        m_data_next        = m_data_reg;
        m_found_index_next = m_found_index_reg;
        m_found_next       = m_found_reg;
        m_count_next       = m_count_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            plse_pkg::ST_IDLE: begin
                if (s_valid) begin
                    func_next  = plse_pkg::func_t'(s_func);
                    pos_next   = s_position;
                    value_next = DATA_WIDTH'(s_value);
                    state_next = plse_pkg::ST_EXEC;
                end
            end
            plse_pkg::ST_EXEC: begin
                reject_next = reject_c;
                if (!reject_c) begin
                    if (ins_c) begin
                        count_next = count_reg + CW'(1);
                    end else if (rem_c || (func_reg == plse_pkg::FUNC_POP)) begin
                        count_next = count_reg - CW'(1);
                    end
                end
                lvl_next   = '0;
                state_next = plse_pkg::ST_TREE;
            end
            plse_pkg::ST_TREE: begin
                lvl_next = lvl_reg + LCW'(1);
                if (lvl_reg == LCW'(IW - 1)) begin
                    state_next = plse_pkg::ST_RESP;
                end
            end
            plse_pkg::ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = reject_reg;
                    m_data_next   = (wants_data && !reject_reg) ?
                                    plse_pkg::DATA_OUT_W'(root_data) : '0;
                    m_found_next  = ctrl.srch && root_hit;
                    if (ctrl.srch) begin
                        m_found_index_next = root_hit ? plse_pkg::COUNT_OUT_W'(root_idx)
                                                      : plse_pkg::COUNT_OUT_W'(count_reg);
                    end else begin
                        m_found_index_next = '0;
                    end
                    m_count_next = plse_pkg::COUNT_OUT_W'(count_reg);
                    state_next   = plse_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = plse_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= plse_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg          <= func_next;
        pos_reg           <= pos_next;
        value_reg         <= value_next;
        reject_reg        <= reject_next;
        lvl_reg           <= lvl_next;
        m_status_reg      <= m_status_next;
        m_data_reg        <= m_data_next;
        m_found_index_reg <= m_found_index_next;
        m_found_reg       <= m_found_next;
        m_count_reg       <= m_count_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_data        = m_data_reg;
    assign m_found_index = m_found_index_reg;
    assign m_found       = m_found_reg;
    assign m_count       = m_count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_C)
        else $error("fill count above capacity");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == plse_pkg::ST_EXEC))
        else $error("accepted item did not enter execute");

    a_ins_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.ins |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the list");

    a_reject_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == plse_pkg::ST_EXEC) && reject_c) |=> $stable(count_reg))
        else $error("rejected operation changed the fill count");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_found) |-> (!m_status && (m_found_index < m_count)))
        else $error("found result inconsistent");

endmodule
